[hdl/p4pe_pkg.sv]
// Shared types and constants for the packed 4bpp pixel engine.
// Used by every module of the block; no dependencies of its own.
package p4pe_pkg;

  // Store and coordinate sizing
  localparam int STORE_BYTES = 131072;
  localparam int COORD_BITS  = 10;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Field widths of the channels and registers
  localparam int COLOR_W     = 4;
  localparam int ACTION_W    = 2;
  localparam int PITCH_W     = 10;
  localparam int DIM_W       = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  // Address arithmetic widths
  localparam int PROD_W = COORD_BITS + PITCH_W;
  localparam int LAST_W = PROD_W + 1;
  localparam int CMP_W  = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Command codes
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HSPAN = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_VSPAN = 2'd3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_PITCH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXELS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINES      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RASTER_XOR = 2'd3;

  // Register reset values
  localparam logic [PITCH_W-1:0] PITCH_RESET  = 10'd320;
  localparam logic [DIM_W-1:0]   PIXELS_RESET = 11'd640;
  localparam logic [DIM_W-1:0]   LINES_RESET  = 11'd400;

  // Nibble masks
  localparam logic [7:0] NIB_LO_MASK = 8'h0f;
  localparam logic [7:0] NIB_HI_MASK = 8'hf0;

  typedef struct packed {
    logic [PITCH_W-1:0] line_pitch;
    logic [DIM_W-1:0]   pixels_per_line;
    logic [DIM_W-1:0]   line_count;
    logic               raster_xor;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic                  reject;
    logic [ACTION_W-1:0]   action;
    logic [ADDR_W-1:0]     addr;
    logic [COORD_BITS-1:0] count;
    logic                  odd;
    logic [COLOR_W-1:0]    color;
  } op_t;

endpackage

[hdl/p4pe_cmd_if.sv]
// Command channel of the pixel engine: valid/ready plus command payload.
// Depends on p4pe_pkg for field widths.
interface p4pe_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [p4pe_pkg::ACTION_W-1:0]       action;
  logic [p4pe_pkg::COORD_BITS-1:0]     x_coord;
  logic [p4pe_pkg::COORD_BITS-1:0]     y_coord;
  logic [p4pe_pkg::COORD_BITS-1:0]     end_coord;
  logic [p4pe_pkg::COLOR_W-1:0]        color;

  modport source (output valid, action, x_coord, y_coord, end_coord, color, input ready);
  modport sink (input valid, action, x_coord, y_coord, end_coord, color, output ready);
endinterface

[hdl/p4pe_res_if.sv]
// Result channel of the pixel engine: valid/ready plus pixel and status.
// Depends on p4pe_pkg for field widths.
interface p4pe_res_if;
  logic                          valid;
  logic                          ready;
  logic [p4pe_pkg::COLOR_W-1:0]  pixel_value;
  logic                          status;

  modport source (output valid, pixel_value, status, input ready);
  modport sink (input valid, pixel_value, status, output ready);
endinterface

[hdl/p4pe_front.sv]
// Front end: accepts commands, checks bounds, forms the byte address.
// Depends on p4pe_pkg and p4pe_cmd_if.
module p4pe_front (
  input  logic              clk,
  input  logic              rst,
  p4pe_cmd_if.sink          cmd,
  input  p4pe_pkg::cfg_t    cfg,
  input  logic              clearing,
  input  logic              q_full,
  output logic              q_push,
  output p4pe_pkg::op_t     q_op
);

  // Stage 1: captured command with bounds verdict
  logic                                s1_valid;
  logic [p4pe_pkg::ACTION_W-1:0]       s1_action;
  logic [p4pe_pkg::COORD_BITS-1:0]     s1_x;
  logic [p4pe_pkg::COORD_BITS-1:0]     s1_y;
  logic [p4pe_pkg::COORD_BITS-1:0]     s1_e;
  logic [p4pe_pkg::COLOR_W-1:0]        s1_color;
  logic                                s1_bad;

  // Stage 2: row product and span length
  logic                                s2_valid;
  logic [p4pe_pkg::ACTION_W-1:0]       s2_action;
  logic [p4pe_pkg::COORD_BITS-1:0]     s2_x;
  logic [p4pe_pkg::COORD_BITS-1:0]     s2_e;
  logic [p4pe_pkg::COLOR_W-1:0]        s2_color;
  logic                                s2_bad;
  logic [p4pe_pkg::COORD_BITS-1:0]     s2_count;
  logic [p4pe_pkg::PROD_W-1:0]         s2_prod;

  logic                                accept;
  logic                                s2_adv;
  logic                                bad_next;
  logic [p4pe_pkg::CMP_W-1:0]          x_ext;
  logic [p4pe_pkg::CMP_W-1:0]          y_ext;
  logic [p4pe_pkg::CMP_W-1:0]          e_ext;
  logic [p4pe_pkg::CMP_W-1:0]          ppl_ext;
  logic [p4pe_pkg::CMP_W-1:0]          lc_ext;
  logic [p4pe_pkg::COORD_BITS-1:0]     row;
  logic [p4pe_pkg::COORD_BITS-1:0]     count_next;
  logic [p4pe_pkg::LAST_W-1:0]         x_half;
  logic [p4pe_pkg::LAST_W-1:0]         e_half;
  logic [p4pe_pkg::LAST_W-1:0]         start_addr;
  logic [p4pe_pkg::LAST_W-1:0]         last_addr;

  // Handshake: stage 2 drains into the queue, stage 1 into stage 2
  assign q_push    = s2_valid && !q_full;
  assign s2_adv    = !s2_valid || q_push;
  assign cmd.ready = (!s1_valid || s2_adv) && !clearing;
  assign accept    = cmd.valid && cmd.ready;

  // Bounds check on the incoming command
  always_comb begin
    x_ext   = p4pe_pkg::CMP_W'(cmd.x_coord);
    y_ext   = p4pe_pkg::CMP_W'(cmd.y_coord);
    e_ext   = p4pe_pkg::CMP_W'(cmd.end_coord);
    ppl_ext = p4pe_pkg::CMP_W'(cfg.pixels_per_line);
    lc_ext  = p4pe_pkg::CMP_W'(cfg.line_count);
    bad_next = (x_ext >= ppl_ext) || (y_ext >= lc_ext);
    case (cmd.action)
      p4pe_pkg::ACT_HSPAN: bad_next = bad_next || (e_ext < x_ext) || (e_ext >= ppl_ext);
      p4pe_pkg::ACT_VSPAN: bad_next = bad_next || (e_ext < y_ext) || (e_ext >= lc_ext);
      default: ;
    endcase
  end

  // Row factor and pixel count for stage 2
  always_comb begin
    row        = (s1_action == p4pe_pkg::ACT_VSPAN) ? s1_e : s1_y;
    count_next = '0;
    case (s1_action)
      p4pe_pkg::ACT_HSPAN: count_next = s1_e - s1_x;
      p4pe_pkg::ACT_VSPAN: count_next = s1_e - s1_y;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= cmd.action;
      s1_x      <= cmd.x_coord;
      s1_y      <= cmd.y_coord;
      s1_e      <= cmd.end_coord;
      s1_color  <= cmd.color;
      s1_bad    <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_action <= s1_action;
      s2_x      <= s1_x;
      s2_e      <= s1_e;
      s2_color  <= s1_color;
      s2_bad    <= s1_bad;
      s2_count  <= count_next;
      s2_prod   <= p4pe_pkg::PROD_W'(row) * p4pe_pkg::PROD_W'(cfg.line_pitch);
    end
  end

  // Form start and last byte addresses, reject beyond the store
  always_comb begin
    x_half     = p4pe_pkg::LAST_W'(s2_x >> 1);
    e_half     = p4pe_pkg::LAST_W'(s2_e >> 1);
    start_addr = p4pe_pkg::LAST_W'(s2_prod) + x_half;
    last_addr  = p4pe_pkg::LAST_W'(s2_prod) +
                 ((s2_action == p4pe_pkg::ACT_HSPAN) ? e_half : x_half);
    q_op.reject = s2_bad || (last_addr >= p4pe_pkg::LAST_W'(p4pe_pkg::STORE_BYTES));
    q_op.action = s2_action;
    // vertical spans walk upward from the last row
    q_op.addr   = (s2_action == p4pe_pkg::ACT_HSPAN) ?
                  p4pe_pkg::ADDR_W'(start_addr) : p4pe_pkg::ADDR_W'(last_addr);
    q_op.count  = s2_count;
    q_op.odd    = s2_x[0];
    q_op.color  = s2_color;
  end

endmodule

[hdl/p4pe_queue.sv]
// Short command queue between the front end and the store sequencer.
// Depends on p4pe_pkg for the entry type and depth.
module p4pe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  p4pe_pkg::op_t     push_op,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output p4pe_pkg::op_t     head
);

  p4pe_pkg::op_t                entries [p4pe_pkg::QUEUE_DEPTH];
  logic [p4pe_pkg::PTR_W-1:0]   wr_ptr;
  logic [p4pe_pkg::PTR_W-1:0]   rd_ptr;
  logic [p4pe_pkg::PTR_W:0]     fill;

  assign full  = (fill == (p4pe_pkg::PTR_W + 1)'(p4pe_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == p4pe_pkg::PTR_W'(p4pe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == p4pe_pkg::PTR_W'(p4pe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[hdl/p4pe_back.sv]
// Store sequencer: owns the frame store, clears it after reset and runs
// read-modify-write per pixel. Depends on p4pe_pkg and p4pe_res_if.
module p4pe_back (
  input  logic              clk,
  input  logic              rst,
  input  p4pe_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  p4pe_pkg::op_t     q_head,
  output logic              q_pop,
  output logic              clearing,
  p4pe_res_if.source        res
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_MODIFY = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [7:0]                         mem [p4pe_pkg::STORE_BYTES];
  logic [7:0]                         rd_data;
  logic                               mem_we;
  logic [p4pe_pkg::ADDR_W-1:0]        mem_waddr;
  logic [7:0]                         mem_wdata;

  logic [2:0]                         state;
  logic [2:0]                         state_next;
  logic [p4pe_pkg::ADDR_W-1:0]        clr_addr;
  p4pe_pkg::op_t                      cur;
  logic [p4pe_pkg::COLOR_W-1:0]       pend_pix;
  logic                               pend_bad;

  logic                               res_valid;
  logic [p4pe_pkg::COLOR_W-1:0]       res_pix;
  logic                               res_bad;
  logic                               res_load;

  logic [7:0]                         bits;
  logic [7:0]                         new_byte;
  logic [p4pe_pkg::COLOR_W-1:0]       read_pix;

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign res_load = (state == ST_RESULT) && (!res_valid || res.ready);

  // Nibble merge for the byte under update
  always_comb begin
    bits     = cur.odd ? {4'h0, cur.color} : {cur.color, 4'h0};
    new_byte = cfg.raster_xor ? (rd_data ^ bits) :
               ((rd_data & (cur.odd ? p4pe_pkg::NIB_HI_MASK : p4pe_pkg::NIB_LO_MASK)) | bits);
    read_pix = cur.odd ? rd_data[3:0] : rd_data[7:4];
  end

  // Store write port: clearing pass or pixel update
  always_comb begin
    mem_we    = clearing || ((state == ST_MODIFY) && (cur.action != p4pe_pkg::ACT_READ));
    mem_waddr = clearing ? clr_addr : cur.addr;
    mem_wdata = clearing ? 8'h00 : new_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cur.addr];
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == p4pe_pkg::ADDR_W'(p4pe_pkg::STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_head.reject ? ST_RESULT : ST_READ;
        end
      end
      ST_READ: state_next = ST_MODIFY;
      ST_MODIFY: begin
        if (cur.action == p4pe_pkg::ACT_READ || cur.count == '0) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_RESULT: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Hold the current command and step it along the span
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_head;
      pend_pix <= '0;
      pend_bad <= q_head.reject;
    end else if (state == ST_MODIFY) begin
      if (cur.action == p4pe_pkg::ACT_READ) begin
        pend_pix <= read_pix;
      end else if (cur.count != '0) begin
        cur.count <= cur.count - 1'b1;
        if (cur.action == p4pe_pkg::ACT_HSPAN) begin
          cur.odd <= !cur.odd;
          if (cur.odd) begin
            cur.addr <= cur.addr + 1'b1;
          end
        end else begin
          cur.addr <= cur.addr - p4pe_pkg::ADDR_W'(cfg.line_pitch);
        end
      end
    end
  end

  // Result register: holds a finished result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_pix <= pend_pix;
      res_bad <= pend_bad;
    end
  end

  assign res.valid       = res_valid;
  assign res.pixel_value = res_pix;
  assign res.status      = res_bad;

endmodule

[hdl/packed_4bpp_pixel_engine.sv]
// Top level of the packed 4bpp pixel engine: configuration registers,
// front end, command queue and store sequencer.
// Depends on p4pe_pkg, p4pe_cmd_if, p4pe_res_if, p4pe_front, p4pe_queue, p4pe_back.
//
// Usage:
//   cmd carries one drawing command per beat (write pixel, read pixel,
//   horizontal span, vertical span); res returns one beat per command with
//   the pixel read (zero otherwise) and a status bit (1 = rejected, store
//   untouched). Registers are written through cfg_we/cfg_index/cfg_data
//   while no command is in flight.
//   After reset the frame store is zeroed one byte per cycle, all 131072
//   bytes, with cmd.ready low; register writes are taken during that pass.
//   A command passes the front end's stage 1 and stage 2 registers and the
//   queue; the sequencer pops it, does a read step and a modify step per
//   pixel, then loads the result register. A rejected command goes from the
//   queue straight to the result register. The store sequencer sets the pace
//   with one read-modify-write per pixel on the single store port (a read
//   command only reads) and pops no new command until its result is loaded.
//   The front end and a 2-entry queue keep taking commands while a result
//   waits in the output register; when the receiver stalls, the sequencer
//   holds its finished result and the queue fills before cmd.ready drops.
module packed_4bpp_pixel_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  p4pe_cmd_if.sink                             cmd,
  p4pe_res_if.source                           res,
  input  logic                                 cfg_we,
  input  logic [p4pe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [p4pe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  p4pe_pkg::cfg_t   cfg;
  p4pe_pkg::op_t    q_op;
  p4pe_pkg::op_t    q_head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             clearing;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_pitch      <= p4pe_pkg::PITCH_RESET;
      cfg.pixels_per_line <= p4pe_pkg::PIXELS_RESET;
      cfg.line_count      <= p4pe_pkg::LINES_RESET;
      cfg.raster_xor      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        p4pe_pkg::REG_LINE_PITCH: cfg.line_pitch      <= cfg_data[p4pe_pkg::PITCH_W-1:0];
        p4pe_pkg::REG_PIXELS:     cfg.pixels_per_line <= cfg_data[p4pe_pkg::DIM_W-1:0];
        p4pe_pkg::REG_LINES:      cfg.line_count      <= cfg_data[p4pe_pkg::DIM_W-1:0];
        p4pe_pkg::REG_RASTER_XOR: cfg.raster_xor      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  p4pe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_op)
  );

  p4pe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_op),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  p4pe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res      (res)
  );

  // No push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command queue overflow");

  // No pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command queue underflow");

  // No command taken while the store is being cleared
  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(cmd.valid && cmd.ready))
    else $error("command accepted during store clear");

  // The sequencer never starts a command during the clearing pass
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("queue popped during store clear");

endmodule

[tb/tb.sv]
// Self-checking bench for packed_4bpp_pixel_engine: drives draw/read commands,
// predicts each status/pixel beat from a shadow frame store or the directed plan.
// Depends on p4pe_pkg, p4pe_cmd_if, p4pe_res_if and the engine RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import p4pe_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
    logic [COORD_BITS-1:0] end_coord;
    logic [COLOR_W-1:0]    color;
  } draw_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic               status;
  } draw_res_t;

  // One row of the directed plan: either a settings change or a command
  typedef struct packed {
    logic               is_cfg;
    draw_cmd_t          cmd;
    logic [PITCH_W-1:0] pitch;
    logic [DIM_W-1:0]   ppl;
    logic [DIM_W-1:0]   lines;
    logic               xr;
    logic               typed;
    draw_res_t          want;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  p4pe_cmd_if cmd_bus ();
  p4pe_res_if res_bus ();

  packed_4bpp_pixel_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .res       (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the frame store and of the live settings
  bit   [7:0]         shadow_frame [STORE_BYTES];
  logic [PITCH_W-1:0] cur_pitch = PITCH_RESET;
  logic [DIM_W-1:0]   cur_ppl   = PIXELS_RESET;
  logic [DIM_W-1:0]   cur_lines = LINES_RESET;
  logic               cur_xor   = 1'b0;

  draw_res_t draw_outcomes [$];
  plan_row_t plan [$];
  int        mismatch_count = 0;
  int        send_gap_pct   = 8;
  int        recv_stall_pct = 67;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned frame_addr(int unsigned x, int unsigned y);
    return (x >> 1) + y * cur_pitch;
  endfunction

  // Replace or XOR one nibble of the shadow store
  function automatic void blend_pixel(int unsigned x, int unsigned y, logic [COLOR_W-1:0] c);
    int unsigned a;
    logic [7:0]  bits;
    a = frame_addr(x, y);
    bits = x[0] ? {4'h0, c} : {c, 4'h0};
    if (cur_xor)
      shadow_frame[a] = shadow_frame[a] ^ bits;
    else
      shadow_frame[a] = (shadow_frame[a] & (x[0] ? NIB_HI_MASK : NIB_LO_MASK)) | bits;
  endfunction

  // Apply one command to the shadow store and return the beat it owes
  function automatic draw_res_t draw_and_report(draw_cmd_t c);
    int unsigned x, y, e, last, i, a;
    bit          bad;
    draw_res_t   r;
    x = 32'(c.x_coord);
    y = 32'(c.y_coord);
    e = 32'(c.end_coord);
    r = '0;
    bad = (x >= cur_ppl) || (y >= cur_lines);
    if (!bad) begin
      if (c.action == ACT_HSPAN)
        bad = (e < x) || (e >= cur_ppl);
      else if (c.action == ACT_VSPAN)
        bad = (e < y) || (e >= cur_lines);
    end
    if (!bad) begin
      case (c.action)
        ACT_HSPAN: last = frame_addr(e, y);
        ACT_VSPAN: last = frame_addr(x, e);
        default:   last = frame_addr(x, y);
      endcase
      bad = last >= STORE_BYTES;
    end
    if (!bad) begin
      case (c.action)
        ACT_WRITE: blend_pixel(x, y, c.color);
        ACT_READ: begin
          a = frame_addr(x, y);
          r.pixel_value = x[0] ? shadow_frame[a][3:0] : shadow_frame[a][7:4];
        end
        ACT_HSPAN: for (i = x; i <= e; i++) blend_pixel(i, y, c.color);
        default:   for (i = y; i <= e; i++) blend_pixel(x, i, c.color);
      endcase
    end
    r.status = bad;
    return r;
  endfunction

  // Random command, mostly in bounds with short spans, the rest noise
  function automatic draw_cmd_t random_command();
    draw_cmd_t c;
    int        xbound, ybound, ylim, xmax, ymax, len, roll, stop;
    c.action    = ACTION_W'($urandom);
    c.color     = COLOR_W'($urandom);
    c.x_coord   = COORD_BITS'($urandom);
    c.y_coord   = COORD_BITS'($urandom);
    c.end_coord = COORD_BITS'($urandom);
    if ($urandom_range(0, 99) < 85 && cur_ppl != 0 && cur_lines != 0) begin
      xbound = (cur_ppl > 1024) ? 1023 : cur_ppl - 1;
      ybound = (cur_lines > 1024) ? 1023 : cur_lines - 1;
      ylim = (cur_pitch == 0) ? 1023 : (STORE_BYTES - 512) / cur_pitch;
      if (ybound > ylim) ybound = ylim;
      xmax = xbound;
      ymax = ybound;
      // keep half the traffic in a small corner so reads hit drawn pixels
      if ($urandom_range(0, 1)) begin
        if (xmax > 31) xmax = 31;
        if (ymax > 15) ymax = 15;
      end
      c.x_coord = COORD_BITS'($urandom_range(0, xmax));
      c.y_coord = COORD_BITS'($urandom_range(0, ymax));
      roll = $urandom_range(0, 99);
      len = (roll < 90) ? $urandom_range(0, 15) :
            (roll < 98) ? $urandom_range(0, 127) : $urandom_range(0, 1023);
      if (c.action == ACT_HSPAN) begin
        stop = c.x_coord + len;
        c.end_coord = COORD_BITS'((stop > xbound) ? xbound : stop);
      end else if (c.action == ACT_VSPAN) begin
        stop = c.y_coord + len;
        c.end_coord = COORD_BITS'((stop > ybound) ? ybound : stop);
      end
    end
    return c;
  endfunction

  function automatic plan_row_t draw(logic [ACTION_W-1:0] act, int x, int y, int e, int c);
    plan_row_t r;
    r = '0;
    r.cmd = '{act, x[COORD_BITS-1:0], y[COORD_BITS-1:0], e[COORD_BITS-1:0], c[COLOR_W-1:0]};
    return r;
  endfunction

  function automatic plan_row_t draw_expect(logic [ACTION_W-1:0] act, int x, int y, int e,
                                            int c, int pix, int st);
    plan_row_t r;
    r = draw(act, x, y, e, c);
    r.typed = 1'b1;
    r.want  = '{pix[COLOR_W-1:0], st[0]};
    return r;
  endfunction

  function automatic plan_row_t settings(int pitch, int ppl, int lines, int xr);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.pitch  = pitch[PITCH_W-1:0];
    r.ppl    = ppl[DIM_W-1:0];
    r.lines  = lines[DIM_W-1:0];
    r.xr     = xr[0];
    return r;
  endfunction

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write all four registers; unused upper data bits carry noise
  task automatic apply_settings(logic [PITCH_W-1:0] pitch, logic [DIM_W-1:0] ppl,
                                logic [DIM_W-1:0] lines, logic xr);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    put_reg(REG_LINE_PITCH, {noise[CFG_DATA_W-1], pitch});
    put_reg(REG_PIXELS, ppl);
    put_reg(REG_LINES, lines);
    put_reg(REG_RASTER_XOR, {noise[CFG_DATA_W-1:1], xr});
    cfg_we    <= 1'b0;
    cur_pitch = pitch;
    cur_ppl   = ppl;
    cur_lines = lines;
    cur_xor   = xr;
  endtask

  // Offer one command beat, with a random gap ahead of it
  task automatic issue(draw_cmd_t c);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.action    <= c.action;
    cmd_bus.x_coord   <= c.x_coord;
    cmd_bus.y_coord   <= c.y_coord;
    cmd_bus.end_coord <= c.end_coord;
    cmd_bus.color     <= c.color;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Drop valid, wait for every owed beat, then let the engine go quiet
  task automatic settle(int cycles);
    cmd_bus.valid <= 1'b0;
    while (draw_outcomes.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // Check each result beat against the oldest owed outcome; stall at random
  always @(posedge clk) begin : collect
    draw_res_t want;
    if (res_bus.valid && res_bus.ready) begin
      if (draw_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, got pixel %0d status %0d",
                 $time, res_bus.pixel_value, res_bus.status);
        mismatch_count++;
      end else begin
        want = draw_outcomes.pop_front();
        if (res_bus.pixel_value !== want.pixel_value) begin
          $display("%0t: pixel_value expected %0d, got %0d",
                   $time, want.pixel_value, res_bus.pixel_value);
          mismatch_count++;
        end
        if (res_bus.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, res_bus.status);
          mismatch_count++;
        end
      end
    end
    res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    draw_res_t got;
    draw_cmd_t c;
    int        pitch, ppl, lines, xr;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_LINE_PITCH;
    cfg_data          <= '0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.action    <= ACT_WRITE;
    cmd_bus.x_coord   <= '0;
    cmd_bus.y_coord   <= '0;
    cmd_bus.end_coord <= '0;
    cmd_bus.color     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed plan: reset contents, bounds, spans, store edge, zero pitch/bounds
    plan.push_back(draw_expect(ACT_READ, 0, 0, 0, 0, 0, 0));
    plan.push_back(draw_expect(ACT_READ, 639, 399, 0, 0, 0, 0));
    plan.push_back(draw(ACT_WRITE, 0, 0, 0, 15));
    plan.push_back(draw(ACT_WRITE, 1, 0, 0, 10));
    plan.push_back(draw(ACT_READ, 0, 0, 0, 0));
    plan.push_back(draw(ACT_READ, 1, 0, 0, 0));
    plan.push_back(draw_expect(ACT_WRITE, 640, 0, 0, 7, 0, 1));
    plan.push_back(draw_expect(ACT_WRITE, 0, 400, 0, 7, 0, 1));
    plan.push_back(draw_expect(ACT_READ, 1023, 1023, 1023, 15, 0, 1));
    plan.push_back(draw_expect(ACT_HSPAN, 10, 2, 9, 4, 0, 1));
    plan.push_back(draw(ACT_HSPAN, 0, 5, 639, 5));
    plan.push_back(draw_expect(ACT_HSPAN, 0, 5, 640, 5, 0, 1));
    plan.push_back(draw(ACT_VSPAN, 3, 10, 399, 9));
    plan.push_back(draw_expect(ACT_VSPAN, 3, 20, 19, 9, 0, 1));
    plan.push_back(draw_expect(ACT_VSPAN, 3, 0, 400, 9, 0, 1));
    plan.push_back(draw(ACT_READ, 3, 399, 0, 0));
    plan.push_back(settings(1023, 1024, 1024, 1));
    plan.push_back(draw(ACT_WRITE, 1023, 127, 0, 6));
    plan.push_back(draw_expect(ACT_WRITE, 0, 129, 0, 6, 0, 1));
    plan.push_back(draw_expect(ACT_VSPAN, 0, 100, 200, 6, 0, 1));
    plan.push_back(draw(ACT_READ, 1023, 127, 0, 0));
    plan.push_back(settings(0, 16, 1024, 1));
    plan.push_back(draw(ACT_VSPAN, 4, 0, 2, 3));
    plan.push_back(draw(ACT_READ, 4, 1023, 0, 0));
    plan.push_back(settings(0, 0, 1, 0));
    plan.push_back(draw_expect(ACT_READ, 0, 0, 0, 0, 0, 1));
    plan.push_back(settings(8, 16, 0, 0));
    plan.push_back(draw_expect(ACT_WRITE, 0, 0, 0, 2, 0, 1));
    plan.push_back(settings(320, 640, 400, 0));
    plan.push_back(draw(ACT_HSPAN, 0, 0, 0, 1));
    plan.push_back(draw(ACT_READ, 0, 0, 0, 0));

    for (int n = 0; n < plan.size(); n++) begin
      if (plan[n].is_cfg) begin
        settle(10);
        apply_settings(plan[n].pitch, plan[n].ppl, plan[n].lines, plan[n].xr);
      end else begin
        issue(plan[n].cmd);
        got = draw_and_report(plan[n].cmd);
        draw_outcomes.push_back(plan[n].typed ? plan[n].want : got);
      end
    end

    // Random phases: one settings choice each, idling pattern per group of three
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin pitch = 320;  ppl = 640;  lines = 400;  xr = 0; end
        1: begin pitch = 1023; ppl = 2047; lines = 2047; xr = 1; end
        2: begin pitch = 1;    ppl = 1;    lines = 1024; xr = 0; end
        3: begin pitch = 0;    ppl = 1024; lines = 1024; xr = 1; end
        4: begin pitch = 512;  ppl = 1024; lines = 1024; xr = 0; end
        6: begin pitch = 64;   ppl = 128;  lines = 64;   xr = 1; end
        8: begin pitch = 320;  ppl = 640;  lines = 400;  xr = $urandom_range(0, 1); end
        default: begin
          pitch = $urandom_range(1, 512);
          ppl   = $urandom_range(1, 1024);
          lines = $urandom_range(1, 1024);
          xr    = $urandom_range(0, 1);
        end
      endcase
      case (p / 3)
        0: begin send_gap_pct = 8;  recv_stall_pct = 67; end
        1: begin send_gap_pct = 67; recv_stall_pct = 8;  end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      settle(10);
      apply_settings(PITCH_W'(pitch), DIM_W'(ppl), DIM_W'(lines), xr[0]);
      repeat (205) begin
        c = random_command();
        issue(c);
        draw_outcomes.push_back(draw_and_report(c));
      end
    end

    settle(20);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/p4pe_pkg.sv
hdl/p4pe_cmd_if.sv
hdl/p4pe_res_if.sv
hdl/p4pe_front.sv
hdl/p4pe_queue.sv
hdl/p4pe_back.sv
hdl/packed_4bpp_pixel_engine.sv
tb/tb.sv
